@@ rtl/closest_points_two_lines_core_defines.svh @@
// assertion macros for the closest points core
`ifndef CLOSEST_POINTS_TWO_LINES_CORE_DEFINES_SVH
`define CLOSEST_POINTS_TWO_LINES_CORE_DEFINES_SVH

`ifndef SYNTH
// antecedent holds in this cycle, consequent in the same cycle
`define CPTL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cptl assertion failed");
// antecedent holds in this cycle, consequent in the next one
`define CPTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cptl assertion failed");
`else
`define CPTL_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CPTL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/cptl_pkg.sv @@
package cptl_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // bits of the second operand taken per multiplier stage
  localparam int MUL_CHUNK = 16;
  // sign stage, scale stage, range stage, one stage per quotient bit, clamp stage
  localparam int DIV_STAGES = WORD_BITS + 4;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] base_one_x;
    logic signed [WORD_BITS-1:0] base_one_y;
    logic signed [WORD_BITS-1:0] base_one_z;
    logic signed [WORD_BITS-1:0] dir_one_x;
    logic signed [WORD_BITS-1:0] dir_one_y;
    logic signed [WORD_BITS-1:0] dir_one_z;
    logic signed [WORD_BITS-1:0] base_two_x;
    logic signed [WORD_BITS-1:0] base_two_y;
    logic signed [WORD_BITS-1:0] base_two_z;
    logic signed [WORD_BITS-1:0] dir_two_x;
    logic signed [WORD_BITS-1:0] dir_two_y;
    logic signed [WORD_BITS-1:0] dir_two_z;
  } lines_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] param_one;
    logic signed [WORD_BITS-1:0] param_two;
    logic                        degenerate;
  } params_t;

endpackage

@@ rtl/closest_points_two_lines_core.sv @@
// closest points between two 3d lines, fixed point
// input channel lines (lines_valid, lines_stall, lines): one transfer carries
//   base point and direction of both lines, signed q16.16
// output channel params (params_valid, params_stall, params): one transfer per
//   input, giving t on line one and s on line two, rounded and clamped, with
//   degenerate set and both parameters zero for parallel or zero directions
// depth: set by three rounds of chunked wide multipliers (5 stages each) and the
//   two dividers that resolve one quotient bit per stage (36 stages)
// throughput: one transfer per cycle while lines_stall is low, every stage holds its own item
// stall: a stage moves on when it is empty or its successor moves, so while
//   the output waits the pipe closes up its bubbles and still takes new items;
//   lines_stall rises only when every stage holds an item and params is stalled
// reset: rst is synchronous and clears all stage valid bits; data registers
//   keep whatever they held
`include "closest_points_two_lines_core_defines.svh"

module closest_points_two_lines_core #(
  parameter int FRAC_BITS = cptl_pkg::FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              lines_valid,
  output logic              lines_stall,
  input  cptl_pkg::lines_t  lines,
  output logic              params_valid,
  input  logic              params_stall,
  output cptl_pkg::params_t params
);

  localparam int W    = cptl_pkg::WORD_BITS;
  localparam int CH   = cptl_pkg::MUL_CHUNK;
  localparam int AW   = W + 1;             // base point difference
  localparam int EW   = 2 * W + 2;         // direction dot products
  localparam int DAW  = 2 * W + 3;         // d2 . a
  localparam int DNW  = 2 * EW + 1;        // denominator
  localparam int WVW  = W + EW + 1;        // d2*e1 - d1*e2
  localparam int NTW  = AW + WVW + 2;      // numerator of t
  localparam int M1W  = 2 * EW;
  localparam int M2AW = WVW + DAW;
  localparam int M2DW = DNW + DAW;
  localparam int M3W  = NTW + EW;
  localparam int NSW  = ((M3W > M2DW) ? M3W : M2DW) + 1;

  localparam int M1_ST  = (EW + CH - 1) / CH;
  localparam int M2_ST  = (DAW + CH - 1) / CH;
  localparam int M3_ST  = (EW + CH - 1) / CH;
  localparam int DIV_ST = cptl_pkg::DIV_STAGES;

  // stage numbering, 1 is the first register after the input
  localparam int B_M1  = 4;
  localparam int B_DEN = B_M1 + M1_ST;
  localparam int B_M2  = B_DEN + 1;
  localparam int B_NT  = B_M2 + M2_ST;
  localparam int B_M3  = B_NT + 1;
  localparam int B_NS  = B_M3 + M3_ST;
  localparam int B_DV  = B_NS + 1;
  localparam int LAST  = B_DV + DIV_ST;

  typedef struct packed {
    logic signed [AW-1:0]  a0;
    logic signed [AW-1:0]  a1;
    logic signed [AW-1:0]  a2;
    logic signed [DAW-1:0] da;
    logic signed [EW-1:0]  e1;
    logic signed [EW-1:0]  e2;
  } c1_t;

  typedef struct packed {
    logic signed [EW-1:0]  e1;
    logic signed [DNW-1:0] den;
  } c2_t;

  typedef struct packed {
    logic signed [NTW-1:0]  nt;
    logic signed [DNW-1:0]  den;
    logic signed [M2DW-1:0] pda;
    logic signed [M2DW-1:0] pde2;
    logic                   zero;
  } c3_t;

  // ---------------------------------------------------------------------------
  // stage valid bits and per-stage advance
  // ---------------------------------------------------------------------------
  logic [LAST:1] v;
  logic [LAST:1] en;

  for (genvar i = 1; i <= LAST; i++) begin : g_en
    if (i == LAST) begin : g_out
      assign en[i] = !v[i] || !params_stall;
    end else begin : g_mid
      assign en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= lines_valid;
      end
      for (int i = 2; i <= LAST; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign lines_stall  = !en[1];
  assign params_valid = v[LAST];

  // ---------------------------------------------------------------------------
  // stage 1: base point difference a = p2 - p1
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] p1 [3];
  logic signed [W-1:0] p2 [3];
  logic signed [W-1:0] d1 [3];
  logic signed [W-1:0] d2 [3];

  assign p1[0] = lines.base_one_x;
  assign p1[1] = lines.base_one_y;
  assign p1[2] = lines.base_one_z;
  assign d1[0] = lines.dir_one_x;
  assign d1[1] = lines.dir_one_y;
  assign d1[2] = lines.dir_one_z;
  assign p2[0] = lines.base_two_x;
  assign p2[1] = lines.base_two_y;
  assign p2[2] = lines.base_two_z;
  assign d2[0] = lines.dir_two_x;
  assign d2[1] = lines.dir_two_y;
  assign d2[2] = lines.dir_two_z;

  logic signed [AW-1:0] s1_a  [3];
  logic signed [W-1:0]  s1_d1 [3];
  logic signed [W-1:0]  s1_d2 [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        s1_a[k]  <= AW'(p2[k]) - AW'(p1[k]);
        s1_d1[k] <= d1[k];
        s1_d2[k] <= d2[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: per-axis products for the dot products
  // ---------------------------------------------------------------------------
  logic signed [2*W-1:0] s2_e1p [3];
  logic signed [2*W-1:0] s2_e2p [3];
  logic signed [2*W-1:0] s2_e3p [3];
  logic signed [2*W:0]   s2_dap [3];
  logic signed [AW-1:0]  s2_a   [3];
  logic signed [W-1:0]   s2_d1  [3];
  logic signed [W-1:0]   s2_d2  [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        s2_e1p[k] <= s1_d1[k] * s1_d2[k];
        s2_e2p[k] <= s1_d2[k] * s1_d2[k];
        s2_e3p[k] <= s1_d1[k] * s1_d1[k];
        s2_dap[k] <= s1_d2[k] * s1_a[k];
        s2_a[k]   <= s1_a[k];
        s2_d1[k]  <= s1_d1[k];
        s2_d2[k]  <= s1_d2[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: e1 = d1.d2, e2 = d2.d2, e3 = d1.d1, da = d2.a
  // ---------------------------------------------------------------------------
  logic signed [EW-1:0]  s3_e1;
  logic signed [EW-1:0]  s3_e2;
  logic signed [EW-1:0]  s3_e3;
  logic signed [DAW-1:0] s3_da;
  logic signed [AW-1:0]  s3_a  [3];
  logic signed [W-1:0]   s3_d1 [3];
  logic signed [W-1:0]   s3_d2 [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_e1 <= EW'(s2_e1p[0]) + EW'(s2_e1p[1]) + EW'(s2_e1p[2]);
      s3_e2 <= EW'(s2_e2p[0]) + EW'(s2_e2p[1]) + EW'(s2_e2p[2]);
      s3_e3 <= EW'(s2_e3p[0]) + EW'(s2_e3p[1]) + EW'(s2_e3p[2]);
      s3_da <= DAW'(s2_dap[0]) + DAW'(s2_dap[1]) + DAW'(s2_dap[2]);
      for (int k = 0; k < 3; k++) begin
        s3_a[k]  <= s2_a[k];
        s3_d1[k] <= s2_d1[k];
        s3_d2[k] <= s2_d2[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // first multiplier round: e1*e1, e2*e3, d2*e1, d1*e2
  // ---------------------------------------------------------------------------
  logic signed [M1W-1:0] m1_e1e1;
  logic signed [M1W-1:0] m1_e2e3;
  logic signed [M1W-1:0] m1_d2e1 [3];
  logic signed [M1W-1:0] m1_d1e2 [3];

  cptl_mul #(.A_W(EW), .B_W(EW)) u_m1_e1e1 (
    .clk (clk),
    .en  (en[B_M1 +: M1_ST]),
    .a   (s3_e1),
    .b   (s3_e1),
    .p   (m1_e1e1)
  );

  cptl_mul #(.A_W(EW), .B_W(EW)) u_m1_e2e3 (
    .clk (clk),
    .en  (en[B_M1 +: M1_ST]),
    .a   (s3_e2),
    .b   (s3_e3),
    .p   (m1_e2e3)
  );

  for (genvar k = 0; k < 3; k++) begin : g_m1
    cptl_mul #(.A_W(EW), .B_W(EW)) u_d2e1 (
      .clk (clk),
      .en  (en[B_M1 +: M1_ST]),
      .a   (s3_e1),
      .b   (EW'(s3_d2[k])),
      .p   (m1_d2e1[k])
    );

    cptl_mul #(.A_W(EW), .B_W(EW)) u_d1e2 (
      .clk (clk),
      .en  (en[B_M1 +: M1_ST]),
      .a   (s3_e2),
      .b   (EW'(s3_d1[k])),
      .p   (m1_d1e2[k])
    );
  end

  c1_t c1_src;
  c1_t c1 [M1_ST];

  assign c1_src = '{a0: s3_a[0], a1: s3_a[1], a2: s3_a[2], da: s3_da, e1: s3_e1, e2: s3_e2};

  for (genvar k = 0; k < M1_ST; k++) begin : g_c1
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[B_M1]) begin
          c1[0] <= c1_src;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[B_M1+k]) begin
          c1[k] <= c1[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // denominator e1*e1 - e2*e3 and w = d2*e1 - d1*e2
  // ---------------------------------------------------------------------------
  logic signed [DNW-1:0] s9_den;
  logic signed [WVW-1:0] s9_wv [3];
  logic signed [AW-1:0]  s9_a  [3];
  logic signed [DAW-1:0] s9_da;
  logic signed [EW-1:0]  s9_e1;
  logic signed [EW-1:0]  s9_e2;
  logic signed [M1W-1:0] wv_full [3];

  for (genvar k = 0; k < 3; k++) begin : g_wv
    assign wv_full[k] = m1_d2e1[k] - m1_d1e2[k];
  end

  always_ff @(posedge clk) begin
    if (en[B_DEN]) begin
      s9_den <= DNW'(m1_e1e1) - DNW'(m1_e2e3);
      for (int k = 0; k < 3; k++) begin
        s9_wv[k] <= wv_full[k][WVW-1:0];
      end
      s9_a[0] <= c1[M1_ST-1].a0;
      s9_a[1] <= c1[M1_ST-1].a1;
      s9_a[2] <= c1[M1_ST-1].a2;
      s9_da   <= c1[M1_ST-1].da;
      s9_e1   <= c1[M1_ST-1].e1;
      s9_e2   <= c1[M1_ST-1].e2;
    end
  end

  // ---------------------------------------------------------------------------
  // second multiplier round: a*w per axis, da*den, den*e2
  // ---------------------------------------------------------------------------
  logic signed [M2AW-1:0] m2_awv [3];
  logic signed [M2DW-1:0] m2_pda;
  logic signed [M2DW-1:0] m2_pde2;

  for (genvar k = 0; k < 3; k++) begin : g_m2
    cptl_mul #(.A_W(WVW), .B_W(DAW)) u_awv (
      .clk (clk),
      .en  (en[B_M2 +: M2_ST]),
      .a   (s9_wv[k]),
      .b   (DAW'(s9_a[k])),
      .p   (m2_awv[k])
    );
  end

  cptl_mul #(.A_W(DNW), .B_W(DAW)) u_m2_pda (
    .clk (clk),
    .en  (en[B_M2 +: M2_ST]),
    .a   (s9_den),
    .b   (s9_da),
    .p   (m2_pda)
  );

  cptl_mul #(.A_W(DNW), .B_W(DAW)) u_m2_pde2 (
    .clk (clk),
    .en  (en[B_M2 +: M2_ST]),
    .a   (s9_den),
    .b   (DAW'(s9_e2)),
    .p   (m2_pde2)
  );

  c2_t c2_src;
  c2_t c2 [M2_ST];

  assign c2_src = '{e1: s9_e1, den: s9_den};

  for (genvar k = 0; k < M2_ST; k++) begin : g_c2
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[B_M2]) begin
          c2[0] <= c2_src;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[B_M2+k]) begin
          c2[k] <= c2[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // numerator of t and the degenerate flag
  // ---------------------------------------------------------------------------
  logic signed [NTW-1:0]  s15_nt;
  logic                   s15_zero;
  logic signed [DNW-1:0]  s15_den;
  logic signed [EW-1:0]   s15_e1;
  logic signed [M2DW-1:0] s15_pda;
  logic signed [M2DW-1:0] s15_pde2;

  always_ff @(posedge clk) begin
    if (en[B_NT]) begin
      s15_nt   <= NTW'(m2_awv[0]) + NTW'(m2_awv[1]) + NTW'(m2_awv[2]);
      s15_zero <= (c2[M2_ST-1].den == '0);
      s15_den  <= c2[M2_ST-1].den;
      s15_e1   <= c2[M2_ST-1].e1;
      s15_pda  <= m2_pda;
      s15_pde2 <= m2_pde2;
    end
  end

  // ---------------------------------------------------------------------------
  // third multiplier round: num_t * e1
  // ---------------------------------------------------------------------------
  logic signed [M3W-1:0] m3_nte1;

  cptl_mul #(.A_W(NTW), .B_W(EW)) u_m3_nte1 (
    .clk (clk),
    .en  (en[B_M3 +: M3_ST]),
    .a   (s15_nt),
    .b   (s15_e1),
    .p   (m3_nte1)
  );

  c3_t c3_src;
  c3_t c3 [M3_ST];

  assign c3_src = '{nt: s15_nt, den: s15_den, pda: s15_pda, pde2: s15_pde2, zero: s15_zero};

  for (genvar k = 0; k < M3_ST; k++) begin : g_c3
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[B_M3]) begin
          c3[0] <= c3_src;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[B_M3+k]) begin
          c3[k] <= c3[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // numerator of s from the second normal equation
  // ---------------------------------------------------------------------------
  logic signed [NSW-1:0]  s21_ns;
  logic signed [NTW-1:0]  s21_nt;
  logic signed [DNW-1:0]  s21_den;
  logic signed [M2DW-1:0] s21_pde2;
  logic                   s21_zero;

  always_ff @(posedge clk) begin
    if (en[B_NS]) begin
      s21_ns   <= NSW'(m3_nte1) - NSW'(c3[M3_ST-1].pda);
      s21_nt   <= c3[M3_ST-1].nt;
      s21_den  <= c3[M3_ST-1].den;
      s21_pde2 <= c3[M3_ST-1].pde2;
      s21_zero <= c3[M3_ST-1].zero;
    end
  end

  // ---------------------------------------------------------------------------
  // both quotients side by side; the flag rides along
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] q_t;
  logic signed [W-1:0] q_s;

  cptl_div #(.N_W(NTW), .D_W(DNW), .FRAC(FRAC_BITS)) u_div_t (
    .clk (clk),
    .en  (en[B_DV +: DIV_ST]),
    .num (s21_nt),
    .den (s21_den),
    .quo (q_t)
  );

  cptl_div #(.N_W(NSW), .D_W(M2DW), .FRAC(FRAC_BITS)) u_div_s (
    .clk (clk),
    .en  (en[B_DV +: DIV_ST]),
    .num (s21_ns),
    .den (s21_pde2),
    .quo (q_s)
  );

  logic zero_d [DIV_ST];

  for (genvar k = 0; k < DIV_ST; k++) begin : g_zd
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[B_DV]) begin
          zero_d[0] <= s21_zero;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[B_DV+k]) begin
          zero_d[k] <= zero_d[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      params.param_one  <= zero_d[DIV_ST-1] ? '0 : q_t;
      params.param_two  <= zero_d[DIV_ST-1] ? '0 : q_s;
      params.degenerate <= zero_d[DIV_ST-1];
    end
  end

  // degenerate results carry zero parameters
  `CPTL_ASSERT_IMPLY(a_degen_zero, clk, rst, params_valid && params.degenerate, params.param_one == '0 && params.param_two == '0)
  // the input is held off only when every stage is occupied and the output waits
  `CPTL_ASSERT_IMPLY(a_full_stall, clk, rst, lines_stall, (&v) && params_stall)
  // an empty first stage always takes an item
  `CPTL_ASSERT_IMPLY(a_bubble_takes, clk, rst, !v[1], !lines_stall)
  // a delivered result with nothing behind it leaves the output empty
  `CPTL_ASSERT_NEXT(a_drain, clk, rst, v[LAST] && !params_stall && !v[LAST-1], !params_valid)

endmodule

@@ rtl/cptl_mul.sv @@
// pipelined signed multiplier, one chunk of b per stage
module cptl_mul #(
  parameter int A_W = cptl_pkg::WORD_BITS,
  parameter int B_W = cptl_pkg::WORD_BITS
) (
  input  logic                                                         clk,
  input  logic [(B_W + cptl_pkg::MUL_CHUNK - 1) / cptl_pkg::MUL_CHUNK - 1:0] en,
  input  logic signed [A_W-1:0]                                        a,
  input  logic signed [B_W-1:0]                                        b,
  output logic signed [A_W+B_W-1:0]                                    p
);

  localparam int CH  = cptl_pkg::MUL_CHUNK;
  localparam int NS  = (B_W + CH - 1) / CH;
  localparam int BP  = NS * CH;
  localparam int P_W = A_W + BP;

  logic signed [A_W-1:0] a_s [NS];
  logic signed [BP-1:0]  b_s [NS];
  logic signed [P_W-1:0] acc [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic signed [A_W-1:0]  a_in;
    logic signed [BP-1:0]   b_in;
    logic signed [P_W-1:0]  acc_in;
    logic signed [CH:0]     dig;
    logic signed [A_W+CH:0] part;

    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = BP'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_s[k-1];
      assign b_in   = b_s[k-1];
      assign acc_in = acc[k-1];
    end

    // top chunk carries the sign, lower chunks are plain magnitudes
    if (k == NS - 1) begin : g_top
      assign dig = {b_in[k*CH+CH-1], b_in[k*CH +: CH]};
    end else begin : g_low
      assign dig = {1'b0, b_in[k*CH +: CH]};
    end

    assign part = a_in * dig;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        a_s[k] <= a_in;
        b_s[k] <= b_in;
        acc[k] <= acc_in + (P_W'(part) <<< (k * CH));
      end
    end
  end

  assign p = acc[NS-1][A_W+B_W-1:0];

endmodule

@@ rtl/cptl_div.sv @@
// pipelined rounding divider: round(num / den * 2^FRAC), clamped to the word range
module cptl_div #(
  parameter int N_W  = 2 * cptl_pkg::WORD_BITS,
  parameter int D_W  = 2 * cptl_pkg::WORD_BITS,
  parameter int FRAC = cptl_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic [cptl_pkg::DIV_STAGES-1:0]     en,
  input  logic signed [N_W-1:0]               num,
  input  logic signed [D_W-1:0]               den,
  output logic signed [cptl_pkg::WORD_BITS-1:0] quo
);

  localparam int W   = cptl_pkg::WORD_BITS;
  localparam int NR  = N_W + FRAC + 1;
  localparam int DR  = D_W + 1 + W;
  localparam int R_W = ((NR > DR) ? NR : DR) + 1;
  localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINMAG = {1'b1, {(W-1){1'b0}}};

  // sign split
  logic           neg0;
  logic [N_W-1:0] nmag;
  logic [D_W-1:0] dmag;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg0 <= num[N_W-1] ^ den[D_W-1];
      nmag <= num[N_W-1] ? unsigned'(-num) : unsigned'(num);
      dmag <= den[D_W-1] ? unsigned'(-den) : unsigned'(den);
    end
  end

  // scaled numerator plus half divisor, doubled divisor
  logic           neg1;
  logic [R_W-1:0] rem1;
  logic [D_W:0]   dd1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg1 <= neg0;
      rem1 <= (R_W'(nmag) << (FRAC + 1)) + R_W'(dmag);
      dd1  <= {dmag, 1'b0};
    end
  end

  // quotient beyond the word width
  logic           neg2;
  logic           ovf2;
  logic [R_W-1:0] rem2;
  logic [D_W:0]   dd2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      neg2 <= neg1;
      ovf2 <= rem1 >= (R_W'(dd1) << W);
      rem2 <= rem1;
      dd2  <= dd1;
    end
  end

  logic [R_W-1:0] rem_s [W];
  logic [D_W:0]   dd_s  [W];
  logic [W-1:0]   q_s   [W];
  logic           neg_s [W];
  logic           ovf_s [W];

  for (genvar j = 0; j < W; j++) begin : g_bit
    localparam int B = W - 1 - j;
    logic [R_W-1:0] rem_in;
    logic [D_W:0]   dd_in;
    logic [W-1:0]   q_in;
    logic           neg_in;
    logic           ovf_in;
    logic [R_W-1:0] trial;
    logic           ge;
    logic [W-1:0]   q_nx;

    if (j == 0) begin : g_first
      assign rem_in = rem2;
      assign dd_in  = dd2;
      assign q_in   = '0;
      assign neg_in = neg2;
      assign ovf_in = ovf2;
    end else begin : g_next
      assign rem_in = rem_s[j-1];
      assign dd_in  = dd_s[j-1];
      assign q_in   = q_s[j-1];
      assign neg_in = neg_s[j-1];
      assign ovf_in = ovf_s[j-1];
    end

    assign trial = R_W'(dd_in) << B;
    assign ge    = rem_in >= trial;

    always_comb begin
      q_nx    = q_in;
      q_nx[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (en[3+j]) begin
        rem_s[j] <= ge ? rem_in - trial : rem_in;
        dd_s[j]  <= dd_in;
        q_s[j]   <= q_nx;
        neg_s[j] <= neg_in;
        ovf_s[j] <= ovf_in;
      end
    end
  end

  logic [W-1:0] q_last;
  logic [W-1:0] res;

  assign q_last = q_s[W-1];

  always_comb begin
    if (neg_s[W-1]) begin
      if (ovf_s[W-1] || (q_last > MINMAG)) begin
        res = MINMAG;
      end else begin
        res = -q_last;
      end
    end else begin
      if (ovf_s[W-1] || q_last[W-1]) begin
        res = MAXPOS;
      end else begin
        res = q_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[W+3]) begin
      quo <= signed'(res);
    end
  end

endmodule
